### rtl/bls_pkg.sv
// ----------------------------------------------------------------------------
// bls_pkg
// Shared types, codes and constants for the bounded LIFO stack.
// ----------------------------------------------------------------------------
package bls_pkg;

  localparam int DATA_W    = 32;
  localparam int COUNT_W   = 4;
  localparam int DEPTH_DEF = 8;

  typedef logic [1:0]               op_t;
  typedef logic [1:0]               status_t;
  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic [COUNT_W-1:0]       count_t;

  localparam op_t OP_PUSH = 2'd0;
  localparam op_t OP_POP  = 2'd1;
  localparam op_t OP_PEEK = 2'd2;
  localparam op_t OP_DUMP = 2'd3;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_OVERFLOW  = 2'd1;
  localparam status_t ST_UNDERFLOW = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    push;      // write push_value at the top, count up
    logic    pop;       // count down
    logic    rd_top;    // read the top entry
    logic    rd_first;  // read the bottom entry, clear the index
    logic    rd_next;   // read the entry above the index, advance it
    logic    load;      // load the result register
    logic    use_rd;    // result data from the read port, else zero
    status_t status;
    logic    last;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic full;
    logic idx_last;
    logic out_busy;
  } stat_t;

endpackage

### rtl/bls_ctrl.sv
// ----------------------------------------------------------------------------
// bls_ctrl
// Sequencer for the bounded LIFO stack: decodes each transaction and steps
// reads and result loads in the datapath.
// ----------------------------------------------------------------------------
module bls_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  bls_pkg::op_t   operation,
  input  bls_pkg::stat_t stat,
  output bls_pkg::cmd_t  cmd
);
  import bls_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_DUMP = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;

  assign req_stall = !((state == S_IDLE) && !stat.out_busy);
  assign accept    = req_valid && !req_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.status = ST_OK;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.last = 1'b1;
          case (operation)
            OP_PUSH: begin
              cmd.load = 1'b1;
              if (stat.full) begin
                cmd.status = ST_OVERFLOW;
              end else begin
                cmd.push = 1'b1;
              end
            end
            OP_POP, OP_PEEK: begin
              if (stat.empty) begin
                cmd.load   = 1'b1;
                cmd.status = ST_UNDERFLOW;
              end else begin
                cmd.rd_top = 1'b1;
                cmd.pop    = (operation == OP_POP);
                state_next = S_READ;
              end
            end
            default: begin
              if (stat.empty) begin
                cmd.load   = 1'b1;
                cmd.status = ST_UNDERFLOW;
              end else begin
                cmd.rd_first = 1'b1;
                state_next   = S_DUMP;
              end
            end
          endcase
        end
      end
      S_READ: begin
        if (!stat.out_busy) begin
          cmd.load   = 1'b1;
          cmd.use_rd = 1'b1;
          cmd.last   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_DUMP: begin
        if (!stat.out_busy) begin
          cmd.load   = 1'b1;
          cmd.use_rd = 1'b1;
          cmd.last   = stat.idx_last;
          if (stat.idx_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.rd_next = 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### rtl/bls_dp.sv
// ----------------------------------------------------------------------------
// bls_dp
// Datapath for the bounded LIFO stack: entry memory, count, dump index and
// the result register.
// ----------------------------------------------------------------------------
module bls_dp #(
  parameter int DEPTH = bls_pkg::DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  bls_pkg::cmd_t   cmd,
  output bls_pkg::stat_t  stat,
  input  bls_pkg::word_t  push_value,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output bls_pkg::word_t  data_out,
  output bls_pkg::status_t status,
  output bls_pkg::count_t held_count,
  output logic            is_empty,
  output logic            is_full,
  output logic            last_item
);
  import bls_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  word_t          mem [DEPTH];
  word_t          rd_data;
  logic [CW-1:0]  count;
  logic [CW-1:0]  count_next;
  logic [AW-1:0]  idx;
  logic [AW-1:0]  top_addr;
  logic [AW-1:0]  rd_addr;
  logic           rd_en;

  assign top_addr = AW'(count - CW'(1));
  assign rd_en    = cmd.rd_top || cmd.rd_first || cmd.rd_next;

  always_comb begin
    rd_addr = top_addr;
    if (cmd.rd_first) begin
      rd_addr = '0;
    end else if (cmd.rd_next) begin
      rd_addr = idx + AW'(1);
    end
  end

  always_comb begin
    count_next = count;
    if (cmd.push) begin
      count_next = count + CW'(1);
    end else if (cmd.pop) begin
      count_next = count - CW'(1);
    end
  end

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[AW'(count)] <= push_value;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_first) begin
      idx <= '0;
    end else if (cmd.rd_next) begin
      idx <= idx + AW'(1);
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      data_out   <= cmd.use_rd ? rd_data : '0;
      status     <= cmd.status;
      held_count <= COUNT_W'(count_next);
      is_empty   <= (count_next == '0);
      is_full    <= (count_next == CW'(DEPTH));
      last_item  <= cmd.last;
    end
  end

  assign stat.empty    = (count == '0);
  assign stat.full     = (count == CW'(DEPTH));
  assign stat.idx_last = ((CW'(idx) + CW'(1)) == count);
  assign stat.out_busy = rsp_valid && rsp_stall;

endmodule

### rtl/bounded_lifo_stack.sv
// ----------------------------------------------------------------------------
// bounded_lifo_stack
// Bounded last-in-first-out store of signed 32-bit words with push, pop,
// peek and dump operations.
// ----------------------------------------------------------------------------
// Each request transaction carries an operation and a push word. Push, and
// any request refused on a full or empty store, answers in the cycle after
// acceptance with one response transaction. Pop and peek go through the
// registered read port of the entry memory, then the response register.
// Dump reads the bottom word first, then answers with one response per held
// word, bottom first, one per cycle while rsp_stall holds none back; the
// final response of every request has last_item set. The block
// takes one request at a time: req_stall stays high from acceptance until
// the final response has been loaded, and also while a loaded response is
// held back by rsp_stall. Every response reports held_count, is_empty and
// is_full as they stand after the operation; data_out is 0 where no word
// is returned. A stalled response holds its fields until taken.
module bounded_lifo_stack #(
  parameter int DEPTH = bls_pkg::DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  // request channel
  input  logic             req_valid,
  output logic             req_stall,
  input  bls_pkg::op_t     operation,
  input  bls_pkg::word_t   push_value,
  // response channel
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output bls_pkg::word_t   data_out,
  output bls_pkg::status_t status,
  output bls_pkg::count_t  held_count,
  output logic             is_empty,
  output logic             is_full,
  output logic             last_item
);
  import bls_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Decode requests and sequence reads and result loads.
  bls_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .operation (operation),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Hold the entries, the count and the response register.
  bls_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .push_value (push_value),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .data_out   (data_out),
    .status     (status),
    .held_count (held_count),
    .is_empty   (is_empty),
    .is_full    (is_full),
    .last_item  (last_item)
  );

endmodule
